[rtl/att_pkg.sv]
package att_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CorrW = 18;
  localparam int unsigned SumW = 36;
  localparam int unsigned RootW = 32;
  localparam int unsigned CxW = 40;
  localparam int unsigned AngW = 32;
  localparam int unsigned AngTableLen = 24;
  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic signed [AngW-1:0] QuarterTurn = 32'sd1073741824;
  localparam logic [31:0] RadScale = 32'd1686629713;
  localparam logic [14:0] DegScale = 15'd23040;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOffsetX = 2'd0,
    CfgOffsetY = 2'd1,
    CfgOffsetZ = 2'd2
  } cfg_idx_e;

  function automatic logic [AngW-1:0] ang_lut(input int unsigned idx);
    logic [AngW-1:0] v;
    case (idx)
      0: v = 32'd536870912;
      1: v = 32'd316933406;
      2: v = 32'd167458907;
      3: v = 32'd85004756;
      4: v = 32'd42667331;
      5: v = 32'd21354465;
      6: v = 32'd10679838;
      7: v = 32'd5340245;
      8: v = 32'd2670163;
      9: v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/att_isqrt.sv]
module att_isqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [att_pkg::SumW-1:0]  sum_i,
  input  logic [1:0][att_pkg::CorrW-1:0] side_i,
  output logic                      valid_o,
  output logic [att_pkg::RootW-1:0] root_o,
  output logic [1:0][att_pkg::CorrW-1:0] side_o
);
  import att_pkg::*;

  localparam int unsigned Stages = RootW;
  localparam int unsigned RadW = SumW + 28;
  localparam int unsigned RemW = RootW + 2;

  logic [Stages:0]                  vld_q;
  logic [Stages:0][RadW-1:0]        rad_q;
  logic [Stages:0][RemW-1:0]        rem_q;
  logic [Stages:0][RootW-1:0]       res_q;
  logic [Stages:0][1:0][CorrW-1:0]  side_q;

  always_comb begin
    vld_q[0] = valid_i;
    rad_q[0] = {sum_i, 28'd0};
    rem_q[0] = '0;
    res_q[0] = '0;
    side_q[0] = side_i;
  end

  for (genvar s = 0; s < Stages; s++) begin : g_st
    logic [RemW-1:0] trial;
    logic [RemW-1:0] cand;
    logic [RemW-1:0] rem_d;
    logic [RootW-1:0] res_d;
    logic vld_q1;
    logic [RadW-1:0] rad_q1;
    logic [RemW-1:0] rem_q1;
    logic [RootW-1:0] res_q1;
    logic [1:0][CorrW-1:0] side_q1;

    always_comb begin
      trial = {rem_q[s][RemW-3:0], rad_q[s][RadW-1 -: 2]};
      cand = {res_q[s], 2'b01};
      if (trial >= cand) begin
        rem_d = trial - cand;
        res_d = {res_q[s][RootW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        res_d = {res_q[s][RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q1 <= 1'b0;
      end else begin
        vld_q1 <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q1 <= {rad_q[s][RadW-3:0], 2'b00};
      rem_q1 <= rem_d;
      res_q1 <= res_d;
      side_q1 <= side_q[s];
    end

    always_comb begin
      vld_q[s+1] = vld_q1;
      rad_q[s+1] = rad_q1;
      rem_q[s+1] = rem_q1;
      res_q[s+1] = res_q1;
      side_q[s+1] = side_q1;
    end
  end

  assign valid_o = vld_q[Stages];
  assign root_o = res_q[Stages];
  assign side_o = side_q[Stages];

endmodule

[rtl/att_cordic.sv]
module att_cordic #(
  parameter int unsigned CordicSteps = att_pkg::CordicStepsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic [att_pkg::RootW-1:0]        root_i,
  input  logic signed [att_pkg::CorrW-1:0] num_i,
  output logic                             valid_o,
  output logic signed [att_pkg::AngW-1:0]  ang_o
);
  import att_pkg::*;

  localparam int unsigned Steps = (CordicSteps > AngTableLen) ? AngTableLen :
                                  (CordicSteps < 1) ? 1 : CordicSteps;

  logic [Steps:0]                       vld;
  logic signed [CxW-1:0]                cx [Steps+1];
  logic signed [CxW-1:0]                cy [Steps+1];
  logic signed [AngW+1:0]               cz [Steps+1];
  logic [Steps:0]                       zero;
  logic signed [1:0]                    sgn [Steps+1];

  always_comb begin
    vld[0] = valid_i;
    cx[0] = CxW'(root_i);
    cy[0] = CxW'(num_i) <<< 14;
    cz[0] = '0;
    zero[0] = (root_i == '0);
    sgn[0] = (num_i > 0) ? 2'sd1 : (num_i < 0) ? -2'sd1 : 2'sd0;
  end

  for (genvar i = 0; i < Steps; i++) begin : g_it
    logic signed [CxW-1:0] dx, dy, x_d, y_d;
    logic signed [AngW+1:0] z_d;
    logic v1;
    logic signed [CxW-1:0] x1, y1;
    logic signed [AngW+1:0] z1;
    logic zr1;
    logic signed [1:0] sg1;

    always_comb begin
      dx = cy[i] >>> i;
      dy = cx[i] >>> i;
      if (cy[i] > 0) begin
        x_d = cx[i] + dx;
        y_d = cy[i] - dy;
        z_d = cz[i] + (AngW+2)'(ang_lut(i));
      end else begin
        x_d = cx[i] - dx;
        y_d = cy[i] + dy;
        z_d = cz[i] - (AngW+2)'(ang_lut(i));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v1 <= 1'b0;
      end else begin
        v1 <= vld[i];
      end
    end

    always_ff @(posedge clk_i) begin
      x1 <= x_d;
      y1 <= y_d;
      z1 <= z_d;
      zr1 <= zero[i];
      sg1 <= sgn[i];
    end

    always_comb begin
      vld[i+1] = v1;
      cx[i+1] = x1;
      cy[i+1] = y1;
      cz[i+1] = z1;
      zero[i+1] = zr1;
      sgn[i+1] = sg1;
    end
  end

  logic signed [AngW+1:0] z_f;
  logic signed [AngW-1:0] ang_d;
  logic signed [AngW+1:0] qt;

  always_comb begin
    z_f = cz[Steps];
    qt = (AngW+2)'(QuarterTurn);
    if (zero[Steps]) begin
      ang_d = (sgn[Steps] > 0) ? QuarterTurn : (sgn[Steps] < 0) ? -QuarterTurn : '0;
    end else if (z_f > qt) begin
      ang_d = QuarterTurn;
    end else if (z_f < -qt) begin
      ang_d = -QuarterTurn;
    end else begin
      ang_d = AngW'(z_f);
    end
  end

  logic vo_q;
  logic signed [AngW-1:0] ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= vld[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q <= ang_d;
  end

  assign valid_o = vo_q;
  assign ang_o = ang_q;

endmodule

[rtl/att_scale.sv]
module att_scale (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic signed [att_pkg::AngW-1:0] ang_i,
  output logic                            valid_o,
  output logic signed [15:0]              rad_o,
  output logic signed [15:0]              deg_o
);
  import att_pkg::*;

  logic [AngW-1:0] mag;
  logic neg;
  assign neg = ang_i[AngW-1];
  assign mag = neg ? AngW'(-ang_i) : AngW'(ang_i);

  logic v1_q, v2_q;
  logic neg1_q;
  logic [63:0] rprod_q;
  logic [46:0] dprod_q;
  logic signed [15:0] rad_q, deg_q;
  logic [15:0] rr, dr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign rr = 16'((rprod_q + (64'd1 << 45)) >> 46);
  assign dr = 16'((dprod_q + (47'd1 << 29)) >> 30);

  always_ff @(posedge clk_i) begin
    neg1_q <= neg;
    rprod_q <= 64'(mag) * 64'(RadScale);
    dprod_q <= 47'(mag) * 47'(DegScale);
    rad_q <= neg1_q ? -rr : rr;
    deg_q <= neg1_q ? -dr : dr;
  end

  assign valid_o = v2_q;
  assign rad_o = rad_q;
  assign deg_o = deg_q;

endmodule

[rtl/accel_tilt_angles_top.sv]
// Tilt angle engine: one sample can start every cycle and its result passes
// through one input register, one squaring register, 32 square root stages,
// one register per CORDIC step plus a clamp register, and two scaling stages,
// with a square root that resolves one bit per stage and one CORDIC step per stage.
// Results are strobed with done_o for one cycle and cannot be stalled.
module accel_tilt_angles_top #(
  parameter int unsigned CordicSteps = att_pkg::CordicStepsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [15:0]             sample_x_i,
  input  logic signed [15:0]             sample_y_i,
  input  logic signed [15:0]             sample_z_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [att_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [15:0]                    cfg_data_i,
  output logic                           done_o,
  output logic signed [15:0]             roll_rad_o,
  output logic signed [15:0]             pitch_rad_o,
  output logic signed [15:0]             roll_deg_o,
  output logic signed [15:0]             pitch_deg_o
);
  import att_pkg::*;

  logic signed [15:0] off_x_q, off_y_q, off_z_q;

  assign busy = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= '0;
      off_y_q <= '0;
      off_z_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgOffsetX: off_x_q <= cfg_data_i;
        CfgOffsetY: off_y_q <= cfg_data_i;
        CfgOffsetZ: off_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic v0_q;
  logic signed [CorrW-1:0] rx_q, ry_q, rz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    rx_q <= CorrW'(sample_x_i) - CorrW'(off_x_q);
    ry_q <= CorrW'(sample_y_i) - CorrW'(off_y_q);
    rz_q <= CorrW'(sample_z_i) - (CorrW'(255) - CorrW'(off_z_q));
  end

  logic v1_q;
  logic [SumW-1:0] sr_q, sp_q;
  logic [1:0][CorrW-1:0] nums_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q <= SumW'(rx_q * rx_q) + SumW'(rz_q * rz_q);
    sp_q <= SumW'(ry_q * ry_q) + SumW'(rz_q * rz_q);
    nums_q <= {rx_q, ry_q};
  end

  logic sq_vr, sq_vp;
  logic [RootW-1:0] root_r, root_p;
  logic [1:0][CorrW-1:0] side_r, side_p;

  att_isqrt u_sqrt_roll (
    .clk_i, .rst_ni, .valid_i(v1_q), .sum_i(sr_q), .side_i(nums_q),
    .valid_o(sq_vr), .root_o(root_r), .side_o(side_r)
  );

  att_isqrt u_sqrt_pitch (
    .clk_i, .rst_ni, .valid_i(v1_q), .sum_i(sp_q), .side_i(nums_q),
    .valid_o(sq_vp), .root_o(root_p), .side_o(side_p)
  );

  logic cv_r, cv_p;
  logic signed [AngW-1:0] ang_r, ang_p;

  att_cordic #(.CordicSteps(CordicSteps)) u_cordic_roll (
    .clk_i, .rst_ni, .valid_i(sq_vr), .root_i(root_r), .num_i(side_r[0]),
    .valid_o(cv_r), .ang_o(ang_r)
  );

  att_cordic #(.CordicSteps(CordicSteps)) u_cordic_pitch (
    .clk_i, .rst_ni, .valid_i(sq_vp), .root_i(root_p), .num_i(side_p[1]),
    .valid_o(cv_p), .ang_o(ang_p)
  );

  logic sv_r, sv_p;

  att_scale u_scale_roll (
    .clk_i, .rst_ni, .valid_i(cv_r), .ang_i(ang_r),
    .valid_o(sv_r), .rad_o(roll_rad_o), .deg_o(roll_deg_o)
  );

  att_scale u_scale_pitch (
    .clk_i, .rst_ni, .valid_i(cv_p), .ang_i(ang_p),
    .valid_o(sv_p), .rad_o(pitch_rad_o), .deg_o(pitch_deg_o)
  );

  assign done_o = sv_r & sv_p;

endmodule

[rtl/att_checker.sv]
module att_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic busy,
  input logic done_o,
  input logic signed [15:0] roll_rad_o,
  input logic signed [15:0] pitch_rad_o,
  input logic signed [15:0] roll_deg_o,
  input logic signed [15:0] pitch_deg_o
);
  a_roll_rad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (roll_rad_o <= 16'sd25736 && roll_rad_o >= -16'sd25736)) else $error("roll_rad");
  a_pitch_rad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pitch_rad_o <= 16'sd25736 && pitch_rad_o >= -16'sd25736))
    else $error("pitch_rad");
  a_pitch_deg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pitch_deg_o <= 16'sd23040 && pitch_deg_o >= -16'sd23040)) else $error("pitch_deg");
  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (roll_rad_o[15] == roll_deg_o[15] || roll_deg_o == 0)) else $error("sign");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy) else $error("busy");
endmodule

bind accel_tilt_angles_top att_checker u_att_checker (.*);

[bench/accel_tilt_angles_top_test.sv]
`timescale 1ns / 100ps

module accel_tilt_angles_top_test;
  import att_pkg::*;

  localparam int Steps = 16;
  localparam longint QuarterBam = 64'sd1073741824;
  localparam longint unsigned RadMul = 64'd1686629713;
  localparam longint unsigned DegMul = 64'd23040;
  localparam longint AtanSteps [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct {
    logic signed [15:0] roll_rad;
    logic signed [15:0] pitch_rad;
    logic signed [15:0] roll_deg;
    logic signed [15:0] pitch_deg;
  } tilt_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    bit                 typed;
    tilt_t              want;
  } sample_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] sample_x_i = '0;
  logic signed [15:0] sample_y_i = '0;
  logic signed [15:0] sample_z_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  cfg_idx_e cfg_idx_i = CfgOffsetX;
  logic [15:0] cfg_data_i = '0;
  logic done_o;
  logic signed [15:0] roll_rad_o, pitch_rad_o, roll_deg_o, pitch_deg_o;

  longint off_x, off_y, off_z;
  tilt_t pending_tilts[$];
  int errors = 0;
  bit idle_on = 1'b1;

  always #1 clk_i = ~clk_i;

  accel_tilt_angles_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .sample_x_i(sample_x_i), .sample_y_i(sample_y_i), .sample_z_i(sample_z_i),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .done_o(done_o), .roll_rad_o(roll_rad_o),
    .pitch_rad_o(pitch_rad_o), .roll_deg_o(roll_deg_o), .pitch_deg_o(pitch_deg_o)
  );

  function automatic longint unsigned root_u64(longint unsigned v);
    longint unsigned rem, res, bw;
    rem = v;
    res = 0;
    bw = 64'd1 << 62;
    while (bw > rem) bw = bw >> 2;
    while (bw != 0) begin
      if (rem >= res + bw) begin
        rem = rem - (res + bw);
        res = (res >> 1) + bw;
      end else begin
        res = res >> 1;
      end
      bw = bw >> 2;
    end
    return res;
  endfunction

  // Binary angle of atan(num / sqrt(a^2 + b^2)); 2^30 is a quarter turn.
  function automatic longint tilt_bam(longint num, longint a, longint b);
    longint unsigned sq;
    longint cx, cy, cz, dx, dy;
    sq = longint'(a * a) + longint'(b * b);
    cx = longint'(root_u64(sq << 28));
    cy = num * 16384;
    cz = 0;
    if (cx == 0) begin
      return (num > 0) ? QuarterBam : (num < 0) ? -QuarterBam : 0;
    end
    for (int i = 0; i < Steps; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy > 0) begin
        cx += dx; cy -= dy; cz += AtanSteps[i];
      end else begin
        cx -= dx; cy += dy; cz -= AtanSteps[i];
      end
    end
    if (cz > QuarterBam) cz = QuarterBam;
    if (cz < -QuarterBam) cz = -QuarterBam;
    return cz;
  endfunction

  function automatic logic [15:0] bam_scale(longint bam, longint unsigned mul, int sh);
    longint unsigned mag, r;
    mag = (bam < 0) ? longint'(-bam) : bam;
    r = (mag * mul + (64'd1 << (sh - 1))) >> sh;
    return (bam < 0) ? 16'(-r) : 16'(r);
  endfunction

  function automatic tilt_t predict_tilt(logic signed [15:0] sx, logic signed [15:0] sy,
                                         logic signed [15:0] sz);
    longint rx, ry, rz, roll, pitch;
    tilt_t t;
    rx = longint'(sx) - off_x;
    ry = longint'(sy) - off_y;
    rz = longint'(sz) - (255 - off_z);
    roll = tilt_bam(ry, rx, rz);
    pitch = tilt_bam(rx, ry, rz);
    t.roll_rad = bam_scale(roll, RadMul, 46);
    t.pitch_rad = bam_scale(pitch, RadMul, 46);
    t.roll_deg = bam_scale(roll, DegMul, 30);
    t.pitch_deg = bam_scale(pitch, DegMul, 30);
    return t;
  endfunction

  task automatic report_mismatch(string field, logic signed [15:0] got,
                                 logic signed [15:0] want);
    $display("%0t: %s got %0d, expected %0d", $time, field, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    tilt_t w;
    if (rst_ni && done_o) begin
      if (pending_tilts.size() == 0) begin
        $display("%0t: result beat with nothing pending", $time);
        errors++;
      end else begin
        w = pending_tilts.pop_front();
        if (roll_rad_o !== w.roll_rad) report_mismatch("roll_rad", roll_rad_o, w.roll_rad);
        if (pitch_rad_o !== w.pitch_rad) report_mismatch("pitch_rad", pitch_rad_o, w.pitch_rad);
        if (roll_deg_o !== w.roll_deg) report_mismatch("roll_deg", roll_deg_o, w.roll_deg);
        if (pitch_deg_o !== w.pitch_deg) report_mismatch("pitch_deg", pitch_deg_o, w.pitch_deg);
      end
    end
  end

  task automatic send_sample(logic signed [15:0] sx, logic signed [15:0] sy,
                             logic signed [15:0] sz, bit typed, tilt_t want);
    while (idle_on && $urandom_range(99) < 38) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    sample_x_i <= sx;
    sample_y_i <= sy;
    sample_z_i <= sz;
    do @(posedge clk_i); while (busy);
    pending_tilts.push_back(typed ? want : predict_tilt(sx, sy, sz));
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_tilts.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_offset(cfg_idx_e idx, logic [15:0] data);
    while (idle_on && $urandom_range(99) < 38) begin
      cfg_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgOffsetX: off_x = longint'(signed'(data));
      CfgOffsetY: off_y = longint'(signed'(data));
      default:    off_z = longint'(signed'(data));
    endcase
  endtask

  task automatic random_samples(int count);
    logic signed [15:0] v [3];
    for (int n = 0; n < count; n++) begin
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(3))
          0:       v[k] = 16'($urandom_range(600) - 300);
          1:       v[k] = 16'($urandom_range(8000) - 4000);
          2:       v[k] = $urandom_range(2) == 0 ? -16'sd32768 : 16'sd32767;
          default: v[k] = 16'($urandom);
        endcase
      end
      if ($urandom_range(9) == 0) begin
        v[0] = 16'(off_x);
        v[2] = 16'(255 - off_z);
      end
      send_sample(v[0], v[1], v[2], 1'b0, '{default: '0});
    end
  endtask

  sample_row_t directed_rows[] = '{
    '{16'sd0, 16'sd0, 16'sd255, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd0}},
    '{16'sd0, 16'sd100, 16'sd255, 1'b0, '{default: '0}},
    '{16'sd0, -16'sd100, 16'sd255, 1'b0, '{default: '0}},
    '{16'sd100, 16'sd0, 16'sd255, 1'b0, '{default: '0}},
    '{-16'sd100, 16'sd0, 16'sd255, 1'b0, '{default: '0}},
    '{16'sd0, 16'sd0, 16'sd1000, 1'b0, '{default: '0}},
    '{16'sd0, 16'sd0, -16'sd1000, 1'b0, '{default: '0}},
    '{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '{default: '0}},
    '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '{default: '0}},
    '{16'sd32767, -16'sd32768, 16'sd255, 1'b0, '{default: '0}},
    '{-16'sd32768, 16'sd32767, 16'sd0, 1'b0, '{default: '0}},
    '{16'sd1, 16'sd1, 16'sd256, 1'b0, '{default: '0}},
    '{-16'sd1, -16'sd1, 16'sd254, 1'b0, '{default: '0}},
    '{16'sd32767, 16'sd0, 16'sd255, 1'b0, '{default: '0}},
    '{16'sd0, -16'sd32768, 16'sd255, 1'b0, '{default: '0}},
    '{16'sd1000, 16'sd1000, 16'sd1255, 1'b0, '{default: '0}}
  };

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    off_x = 0;
    off_y = 0;
    off_z = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_sample(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                  directed_rows[i].typed, directed_rows[i].want);
    end
    random_samples(240);
    drain();

    idle_on = 1'b0;
    write_offset(CfgOffsetX, 16'h7FFF);
    write_offset(CfgOffsetY, 16'h7FFF);
    write_offset(CfgOffsetZ, 16'h7FFF);
    cfg_valid_i <= 1'b0;
    random_samples(260);
    drain();

    idle_on = 1'b1;
    write_offset(CfgOffsetX, 16'h8000);
    write_offset(CfgOffsetY, 16'h8000);
    write_offset(CfgOffsetZ, 16'h8000);
    cfg_valid_i <= 1'b0;
    random_samples(260);
    drain();

    write_offset(CfgOffsetZ, 16'($urandom_range(400) - 200));
    write_offset(CfgOffsetY, 16'($urandom));
    write_offset(CfgOffsetX, 16'($urandom_range(400) - 200));
    cfg_valid_i <= 1'b0;
    random_samples(260);
    drain();

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
